/* hdl/assert_macros.svh */
// Assertion helpers for the converter top level; they expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hdl/g2e_pkg.sv */
// ----------------------------------------------------------------------------
// g2e_pkg
// Shared types, fixed-point constants and latencies of the geodetic to ECEF
// pipeline.
// ----------------------------------------------------------------------------
package g2e_pkg;

	typedef logic [63:0]        q62_t;
	typedef logic signed [63:0] sq62_t;

	localparam int MUL_LAT      = 2;
	localparam int SMUL_LAT     = 4;
	localparam int SERIES_TERMS = 12;
	localparam int NEWTON_STEPS = 6;
	localparam int SC_LAT       = 2 + 2 * MUL_LAT + SERIES_TERMS * 2 * MUL_LAT;
	localparam int RSQ_LAT      = NEWTON_STEPS * 3 * MUL_LAT;
	localparam int LEN_FRAC     = 24;

	localparam q62_t ONE_Q62   = 64'd1 << 62;
	localparam q62_t THREE_Q62 = 64'd3 << 62;
	localparam q62_t PI_Q60    = 64'h3243F6A8885A308D;

	// pi/180 in Q64
	localparam logic [127:0] RAD_W = {60'd0, PI_Q60, 4'd0} / 128'd180;
	localparam q62_t RAD_Q = RAD_W[63:0];

	// flattening and first eccentricity squared, Q62
	localparam logic [127:0] FQ_W = (128'd1000000000 << 62) / 128'd298257223563;
	localparam logic [127:0] E2_W = (FQ_W << 1) - ((FQ_W * FQ_W) >> 62);
	localparam q62_t E2_Q = E2_W[63:0];

	localparam q62_t SEMI_MAJOR_MM = 64'd6378137000;

endpackage

/* hdl/g2e_mul.sv */
// ----------------------------------------------------------------------------
// g2e_mul
// 64x64 unsigned multiply from four 32x32 partial products, two stages,
// result is the low 64 bits of the product shifted right by SHIFT.
// ----------------------------------------------------------------------------
module g2e_mul #(
	parameter int SHIFT = 62
) (
	input  logic          clk,
	input  logic          en,
	input  g2e_pkg::q62_t a,
	input  g2e_pkg::q62_t b,
	output g2e_pkg::q62_t p
);

	logic [63:0]  ll_s1, lh_s1, hl_s1, hh_s1;
	logic [127:0] sum;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[31:0] * b[31:0];
			lh_s1 <= a[31:0] * b[63:32];
			hl_s1 <= a[63:32] * b[31:0];
			hh_s1 <= a[63:32] * b[63:32];
		end
	end

	always_comb begin
		sum = {hh_s1, 64'd0} + {32'd0, lh_s1, 32'd0} + {32'd0, hl_s1, 32'd0}
			+ {64'd0, ll_s1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= 64'(sum >> SHIFT);
		end
	end

endmodule

/* hdl/g2e_dly.sv */
// ----------------------------------------------------------------------------
// g2e_dly
// Shift line that keeps side data aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
module g2e_dly #(
	parameter int W = 64,
	parameter int D = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[D-1];

endmodule

/* hdl/g2e_smul.sv */
// ----------------------------------------------------------------------------
// g2e_smul
// Signed value times signed Q62 fraction in sign-magnitude form, four stages.
// ----------------------------------------------------------------------------
module g2e_smul (
	input  logic           clk,
	input  logic           en,
	input  g2e_pkg::sq62_t a,
	input  g2e_pkg::sq62_t b,
	output g2e_pkg::sq62_t p
);

	import g2e_pkg::*;

	q62_t ma_s1, mb_s1, mp;
	logic neg_s1, neg_s2, neg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[63] ^ b[63];
			ma_s1  <= a[63] ? q62_t'(-a) : q62_t'(a);
			mb_s1  <= b[63] ? q62_t'(-b) : q62_t'(b);
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			p      <= sq62_t'(neg_s3 ? 64'd0 - mp : mp);
		end
	end

	g2e_mul #(.SHIFT(62)) u_mul (.clk(clk), .en(en), .a(ma_s1), .b(mb_s1), .p(mp));

endmodule

/* hdl/g2e_sincos.sv */
// ----------------------------------------------------------------------------
// g2e_sincos
// Sine and cosine in Q62: octant fold, radian scaling, then a twelve-term
// Taylor series with one pipelined term per four stages.
// ----------------------------------------------------------------------------
module g2e_sincos #(
	parameter int ANGLE_FRAC_BITS = 23
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] angle,
	output g2e_pkg::sq62_t     sin_q,
	output g2e_pkg::sq62_t     cos_q
);

	import g2e_pkg::*;

	localparam logic [31:0] U45  = 32'(45) << ANGLE_FRAC_BITS;
	localparam logic [31:0] U90  = 32'(90) << ANGLE_FRAC_BITS;
	localparam logic [31:0] U180 = 32'(180) << ANGLE_FRAC_BITS;

	logic        neg, flipc, swap;
	logic [31:0] mag, fold1, fold2;
	q62_t        a_s1, r, r_d, r2;
	logic [2:0]  flg_s1, flg_d;
	q62_t        ts [SERIES_TERMS+1];
	q62_t        tc [SERIES_TERMS+1];
	q62_t        ss [SERIES_TERMS+1];
	q62_t        cs [SERIES_TERMS+1];
	q62_t        r2v [SERIES_TERMS];
	q62_t        s_pick, c_pick;

	// fold into the first octant
	always_comb begin
		neg   = angle[31];
		mag   = neg ? 32'(-angle) : 32'(angle);
		flipc = mag > U90;
		fold1 = flipc ? U180 - mag : mag;
		swap  = fold1 > U45;
		fold2 = swap ? U90 - fold1 : fold1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= {32'd0, fold2};
			flg_s1 <= {neg, flipc, swap};
		end
	end

	g2e_mul #(.SHIFT(ANGLE_FRAC_BITS + 2)) u_rad (
		.clk(clk), .en(en), .a(a_s1), .b(RAD_Q), .p(r));
	g2e_mul #(.SHIFT(62)) u_sq (.clk(clk), .en(en), .a(r), .b(r), .p(r2));
	g2e_dly #(.W(64), .D(MUL_LAT)) u_r_d (.clk(clk), .en(en), .d(r), .q(r_d));
	g2e_dly #(.W(3), .D(SC_LAT - 2)) u_flg_d (.clk(clk), .en(en), .d(flg_s1), .q(flg_d));

	assign ts[0]  = r_d;
	assign ss[0]  = r_d;
	assign tc[0]  = ONE_Q62;
	assign cs[0]  = ONE_Q62;
	assign r2v[0] = r2;

	for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_term
		localparam int N  = i + 1;
		localparam int DS = (2 * N) * (2 * N + 1);
		localparam int DC = (2 * N - 1) * (2 * N);
		localparam int LS = $clog2(DS);
		localparam int LC = $clog2(DC);
		// floor(x/d) as a multiply by ceil(2^(62+l)/d), exact for x below 2^62
		localparam logic [127:0] MS = ((128'd1 << (62 + LS)) + 128'(DS) - 128'd1) / 128'(DS);
		localparam logic [127:0] MC = ((128'd1 << (62 + LC)) + 128'(DC) - 128'd1) / 128'(DC);

		q62_t ts_m, tc_m, ss_d, cs_d;

		g2e_mul #(.SHIFT(62)) u_ts_m (.clk(clk), .en(en), .a(ts[i]), .b(r2v[i]), .p(ts_m));
		g2e_mul #(.SHIFT(62 + LS)) u_ts_q (
			.clk(clk), .en(en), .a(ts_m), .b(MS[63:0]), .p(ts[i+1]));
		g2e_mul #(.SHIFT(62)) u_tc_m (.clk(clk), .en(en), .a(tc[i]), .b(r2v[i]), .p(tc_m));
		g2e_mul #(.SHIFT(62 + LC)) u_tc_q (
			.clk(clk), .en(en), .a(tc_m), .b(MC[63:0]), .p(tc[i+1]));
		g2e_dly #(.W(64), .D(2 * MUL_LAT)) u_ss_d (.clk(clk), .en(en), .d(ss[i]), .q(ss_d));
		g2e_dly #(.W(64), .D(2 * MUL_LAT)) u_cs_d (.clk(clk), .en(en), .d(cs[i]), .q(cs_d));

		if (i < SERIES_TERMS - 1) begin : g_r2
			g2e_dly #(.W(64), .D(2 * MUL_LAT)) u_r2_d (
				.clk(clk), .en(en), .d(r2v[i]), .q(r2v[i+1]));
		end

		if (N % 2 == 1) begin : g_sub
			assign ss[i+1] = ss_d - ts[i+1];
			assign cs[i+1] = cs_d - tc[i+1];
		end else begin : g_add
			assign ss[i+1] = ss_d + ts[i+1];
			assign cs[i+1] = cs_d + tc[i+1];
		end
	end

	// undo the fold: swap, then apply signs
	always_comb begin
		s_pick = flg_d[0] ? cs[SERIES_TERMS] : ss[SERIES_TERMS];
		c_pick = flg_d[0] ? ss[SERIES_TERMS] : cs[SERIES_TERMS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_q <= sq62_t'(flg_d[2] ? 64'd0 - s_pick : s_pick);
			cos_q <= sq62_t'(flg_d[1] ? 64'd0 - c_pick : c_pick);
		end
	end

endmodule

/* hdl/g2e_rsqrt.sv */
// ----------------------------------------------------------------------------
// g2e_rsqrt
// 1/sqrt(w) in Q62 by six pipelined Newton steps starting at one.
// ----------------------------------------------------------------------------
module g2e_rsqrt (
	input  logic          clk,
	input  logic          en,
	input  g2e_pkg::q62_t w,
	output g2e_pkg::q62_t y
);

	import g2e_pkg::*;

	q62_t yv [NEWTON_STEPS+1];
	q62_t wv [NEWTON_STEPS];

	assign yv[0] = ONE_Q62;
	assign wv[0] = w;

	for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_step
		q62_t yy, t, w_d, y_d;

		g2e_mul #(.SHIFT(62)) u_yy (.clk(clk), .en(en), .a(yv[i]), .b(yv[i]), .p(yy));
		g2e_dly #(.W(64), .D(MUL_LAT)) u_w_d (.clk(clk), .en(en), .d(wv[i]), .q(w_d));
		g2e_mul #(.SHIFT(62)) u_t (.clk(clk), .en(en), .a(w_d), .b(yy), .p(t));
		g2e_dly #(.W(64), .D(2 * MUL_LAT)) u_y_d (.clk(clk), .en(en), .d(yv[i]), .q(y_d));
		g2e_mul #(.SHIFT(63)) u_y (
			.clk(clk), .en(en), .a(y_d), .b(THREE_Q62 - t), .p(yv[i+1]));

		if (i < NEWTON_STEPS - 1) begin : g_w
			g2e_dly #(.W(64), .D(2 * MUL_LAT)) u_w_n (
				.clk(clk), .en(en), .d(w_d), .q(wv[i+1]));
		end
	end

	assign y = yv[NEWTON_STEPS];

endmodule

/* hdl/geodetic_to_ecef_converter.sv */
// ----------------------------------------------------------------------------
// geodetic_to_ecef_converter
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset clears only the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module geodetic_to_ecef_converter #(
	parameter int ANGLE_FRAC_BITS = 23
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// latitude [31:0], longitude [63:32], height_mm [91:64], zero pad
	input  logic [95:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// ecef_x_mm [33:0], ecef_y_mm [67:34], ecef_z_mm [101:68], zero pad
	output logic [103:0] m_axis_tdata,
	// valid_res [0]
	output logic         m_axis_tuser
);

	import g2e_pkg::*;

	localparam int T_SC     = SC_LAT;
	localparam int T_W      = T_SC + 1 + 2 * MUL_LAT + 1;
	localparam int T_Y      = T_W + RSQ_LAT;
	localparam int T_NM     = T_Y + 2 * MUL_LAT;
	localparam int T_NH     = T_NM + 1;
	localparam int T_P      = T_NH + SMUL_LAT;
	localparam int T_X      = T_P + SMUL_LAT;
	localparam int PIPE_LAT = T_X + 1;

	localparam logic signed [31:0] LIM90  = 32'(90) << ANGLE_FRAC_BITS;
	localparam logic signed [31:0] LIM180 = 32'(180) << ANGLE_FRAC_BITS;

	logic               en, in_ok, ok_d;
	logic signed [31:0] lat, lon;
	logic [27:0]        h_d;
	logic [PIPE_LAT-1:0] vld_q;
	sq62_t              slat, clat, slon, clon;
	sq62_t              slat_d, clat_d, slon_d, clon_d;
	q62_t               ms_s1, m1, m2, w_s2, yr, n_q, nm, n_d;
	sq62_t              hq, nh_s3, nbh_s3, p, zq, z_d, xq, yq;

	function automatic logic [33:0] round_mm(sq62_t v);
		logic [63:0] m;
		m = v[63] ? 64'd0 - v : v;
		m = (m + (64'd1 << (LEN_FRAC - 1))) >> LEN_FRAC;
		return v[63] ? 34'(64'd0 - m) : m[33:0];
	endfunction

	assign en            = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[PIPE_LAT-1];

	assign lat   = s_axis_tdata[31:0];
	assign lon   = s_axis_tdata[63:32];
	assign in_ok = (lat >= -LIM90) && (lat <= LIM90) && (lon >= -LIM180) && (lon <= LIM180);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
		end
	end

	g2e_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_lat (
		.clk(clk), .en(en), .angle(lat), .sin_q(slat), .cos_q(clat));
	g2e_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_lon (
		.clk(clk), .en(en), .angle(lon), .sin_q(slon), .cos_q(clon));

	// w = 1 - e2 sin^2 lat
	always_ff @(posedge clk) begin
		if (en) begin
			ms_s1 <= slat[63] ? q62_t'(-slat) : q62_t'(slat);
			w_s2  <= ONE_Q62 - m2;
		end
	end

	g2e_mul #(.SHIFT(62)) u_m1 (.clk(clk), .en(en), .a(ms_s1), .b(ms_s1), .p(m1));
	g2e_mul #(.SHIFT(62)) u_m2 (.clk(clk), .en(en), .a(E2_Q), .b(m1), .p(m2));

	g2e_rsqrt u_rsqrt (.clk(clk), .en(en), .w(w_s2), .y(yr));

	g2e_mul #(.SHIFT(62 - LEN_FRAC)) u_n (
		.clk(clk), .en(en), .a(SEMI_MAJOR_MM), .b(yr), .p(n_q));
	g2e_mul #(.SHIFT(62)) u_nm (.clk(clk), .en(en), .a(n_q), .b(E2_Q), .p(nm));
	g2e_dly #(.W(64), .D(MUL_LAT)) u_n_d (.clk(clk), .en(en), .d(n_q), .q(n_d));
	g2e_dly #(.W(28), .D(T_NM)) u_h_d (
		.clk(clk), .en(en), .d(s_axis_tdata[91:64]), .q(h_d));

	assign hq = {{12{h_d[27]}}, h_d, 24'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			nh_s3  <= sq62_t'(n_d) + hq;
			nbh_s3 <= sq62_t'(n_d - nm) + hq;
		end
	end

	g2e_dly #(.W(64), .D(T_NH - T_SC)) u_clat_d (.clk(clk), .en(en), .d(clat), .q(clat_d));
	g2e_dly #(.W(64), .D(T_NH - T_SC)) u_slat_d (.clk(clk), .en(en), .d(slat), .q(slat_d));
	g2e_dly #(.W(64), .D(T_P - T_SC)) u_clon_d (.clk(clk), .en(en), .d(clon), .q(clon_d));
	g2e_dly #(.W(64), .D(T_P - T_SC)) u_slon_d (.clk(clk), .en(en), .d(slon), .q(slon_d));

	g2e_smul u_p (.clk(clk), .en(en), .a(nh_s3), .b(clat_d), .p(p));
	g2e_smul u_z (.clk(clk), .en(en), .a(nbh_s3), .b(slat_d), .p(zq));
	g2e_smul u_x (.clk(clk), .en(en), .a(p), .b(clon_d), .p(xq));
	g2e_smul u_y (.clk(clk), .en(en), .a(p), .b(slon_d), .p(yq));
	g2e_dly #(.W(64), .D(T_X - T_P)) u_z_d (.clk(clk), .en(en), .d(zq), .q(z_d));
	g2e_dly #(.W(1), .D(T_X)) u_ok_d (.clk(clk), .en(en), .d(in_ok), .q(ok_d));

	// zero the coordinates of an out-of-range item
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= ok_d ? {2'b00, round_mm(z_d), round_mm(yq), round_mm(xq)} : '0;
			m_axis_tuser <= ok_d;
		end
	end

	`ASSERT_IMP(a_zero_invalid, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "invalid item with nonzero coordinates")
	`ASSERT_NXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, $stable(vld_q), "pipeline moved during stall")
	`ASSERT_NXT(a_drain, en && vld_q[PIPE_LAT-2], m_axis_tvalid, "item lost before output register")

endmodule

/* tb/sv/tb_geodetic_to_ecef_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_geodetic_to_ecef_converter
// Streams geodetic points into the converter and checks every ECEF result
// against a bit-exact fixed-point predictor, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_geodetic_to_ecef_converter;
	import g2e_pkg::*;

	localparam int FRAC = 23;
	localparam logic signed [63:0] LIM90  = 64'sd90 << FRAC;
	localparam logic signed [63:0] LIM180 = 64'sd180 << FRAC;

	typedef struct packed {
		logic [33:0] x;
		logic [33:0] y;
		logic [33:0] z;
		logic        ok;
	} ecef_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic         m_axis_tuser;

	ecef_t expected_points[$];
	int    gap_pct;
	int    stall_pct;
	int    n_points;
	int    n_results;
	int    n_invalid;
	int    n_errors;

	geodetic_to_ecef_converter #(.ANGLE_FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

	// (a*b) >> s, low 64 bits
	function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> s);
	endfunction

	function automatic logic signed [63:0] mul_q62(logic signed [63:0] a,
			logic signed [63:0] b);
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] p;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		p = mul_shr(ma, mb, 62);
		return (a[63] != b[63]) ? -$signed(p) : $signed(p);
	endfunction

	function automatic void sin_cos(input logic signed [63:0] k,
			output logic signed [63:0] s, output logic signed [63:0] c);
		logic [63:0] a;
		logic [63:0] r;
		logic [63:0] r2;
		logic [63:0] ts;
		logic [63:0] tc;
		logic [63:0] ss;
		logic [63:0] cs;
		logic [63:0] t;
		logic        flipc;
		logic        swap;
		flipc = 1'b0;
		swap = 1'b0;
		a = k[63] ? -k : k;
		if (a > 64'(LIM90)) begin
			a = 64'(LIM180) - a;
			flipc = 1'b1;
		end
		if (a > (64'd45 << FRAC)) begin
			a = 64'(LIM90) - a;
			swap = 1'b1;
		end
		r = mul_shr(a, RAD_Q, FRAC + 2);
		r2 = mul_shr(r, r, 62);
		ts = r;
		ss = r;
		tc = ONE_Q62;
		cs = ONE_Q62;
		for (int n = 1; n <= 12; n++) begin
			ts = mul_shr(ts, r2, 62) / 64'((2 * n) * (2 * n + 1));
			tc = mul_shr(tc, r2, 62) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) begin
				ss -= ts;
				cs -= tc;
			end else begin
				ss += ts;
				cs += tc;
			end
		end
		if (swap) begin
			t = ss;
			ss = cs;
			cs = t;
		end
		s = k[63] ? -$signed(ss) : $signed(ss);
		c = flipc ? -$signed(cs) : $signed(cs);
	endfunction

	function automatic logic [33:0] to_mm(logic signed [63:0] v);
		logic [63:0] m;
		m = v[63] ? -v : v;
		m = (m + (64'd1 << (LEN_FRAC - 1))) >> LEN_FRAC;
		return v[63] ? 34'(-m) : 34'(m);
	endfunction

	function automatic ecef_t convert_point(logic [31:0] lat_in, logic [31:0] lon_in,
			logic [27:0] h_in);
		ecef_t res;
		logic signed [63:0] lat;
		logic signed [63:0] lon;
		logic signed [63:0] slat;
		logic signed [63:0] clat;
		logic signed [63:0] slon;
		logic signed [63:0] clon;
		logic signed [63:0] nrad;
		logic signed [63:0] nb;
		logic signed [63:0] hq;
		logic signed [63:0] p;
		logic [63:0] ms;
		logic [63:0] w;
		logic [63:0] y;
		logic [63:0] t;
		res = '0;
		lat = 64'(signed'(lat_in));
		lon = 64'(signed'(lon_in));
		if (lat < -LIM90 || lat > LIM90 || lon < -LIM180 || lon > LIM180)
			return res;
		sin_cos(lat, slat, clat);
		sin_cos(lon, slon, clon);
		ms = slat[63] ? -slat : slat;
		w = ONE_Q62 - mul_shr(E2_Q, mul_shr(ms, ms, 62), 62);
		y = ONE_Q62;
		for (int i = 0; i < 6; i++) begin
			t = mul_shr(w, mul_shr(y, y, 62), 62);
			y = mul_shr(y, THREE_Q62 - t, 63);
		end
		nrad = $signed(mul_shr(SEMI_MAJOR_MM, y, 62 - LEN_FRAC));
		nb = nrad - $signed(mul_shr(nrad, E2_Q, 62));
		hq = 64'(signed'(h_in)) <<< LEN_FRAC;
		p = mul_q62(nrad + hq, clat);
		res.x = to_mm(mul_q62(p, clon));
		res.y = to_mm(mul_q62(p, slon));
		res.z = to_mm(mul_q62(nb + hq, slat));
		res.ok = 1'b1;
		return res;
	endfunction

	// valid stays high after an item; the next item or drain() moves it
	task automatic send_point(input logic [31:0] lat, input logic [31:0] lon,
			input logic [27:0] h);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, h, lon, lat};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_points.push_back(convert_point(lat, lon, h));
		n_points++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (expected_points.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		ecef_t got;
		ecef_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[33:0], m_axis_tdata[67:34], m_axis_tdata[101:68],
				m_axis_tuser};
			n_results++;
			if (expected_points.size() == 0) begin
				$error("result item with nothing expected");
				n_errors++;
			end else begin
				want = expected_points.pop_front();
				if (!want.ok)
					n_invalid++;
				if (got.x !== want.x) begin
					$error("ecef_x_mm expected %0d got %0d", $signed(want.x), $signed(got.x));
					n_errors++;
				end
				if (got.y !== want.y) begin
					$error("ecef_y_mm expected %0d got %0d", $signed(want.y), $signed(got.y));
					n_errors++;
				end
				if (got.z !== want.z) begin
					$error("ecef_z_mm expected %0d got %0d", $signed(want.z), $signed(got.z));
					n_errors++;
				end
				if (got.ok !== want.ok) begin
					$error("valid_res expected %0d got %0d", want.ok, got.ok);
					n_errors++;
				end
			end
		end
	end

	function automatic logic [31:0] rand_angle(int lim);
		case ($urandom_range(9))
			0:       return $urandom;
			1:       return $urandom_range(1) ? 32'(lim) : 32'(-lim);
			2:       return $urandom_range(1) ? 32'(lim + 1) : 32'(-lim - 1);
			default: return 32'($urandom_range(2 * lim) - lim);
		endcase
	endfunction

	function automatic logic [27:0] rand_height();
		case ($urandom_range(3))
			0:       return 28'($urandom);
			1:       return 28'($urandom_range(200000000) - 100000000);
			default: return 28'($urandom_range(20000000) - 1000000);
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] lats[8];
		logic [31:0] lons[6];
		lats = '{32'd0, 32'(LIM90), 32'(-LIM90), 32'(LIM90 + 1), 32'h7fffffff,
			32'h80000000, 32'd377487360, 32'd1};
		lons = '{32'd0, 32'(LIM180), 32'(-LIM180), 32'(-LIM180 - 1), 32'd754974720,
			32'hffffffff};
		for (int i = 0; i < 8; i++)
			send_point(lats[i], lons[i % 6], 28'd0);
		send_point(32'd0, 32'd0, 28'h7ffffff);
		send_point(32'd0, 32'd0, 28'h8000000);
		send_point(32'd377487360, 32'd377487360, 28'(100000000));
		send_point(32'(-LIM90), 32'(LIM180), 28'(-100000000));
		send_point(32'd1, 32'(LIM180 + 1), 28'd5);
		send_point(32'(LIM90), 32'h80000000, 28'hfffffff);
		send_point(32'd100000000, 32'd1200000000, 28'd12345);
		send_point(32'hf0000000, 32'(-LIM180), 28'h5555555);
		send_point(32'haaaaaaaa, 32'h55555555, 28'haaaaaaa);
		send_point(32'd188743680, 32'd1132462080, 28'd8848000);
	endtask

	task automatic test_random(input int gap, input int stall, input int count);
		gap_pct = gap;
		stall_pct = stall;
		for (int i = 0; i < count; i++)
			send_point(rand_angle(int'(LIM90)), rand_angle(int'(LIM180)), rand_height());
	endtask

	// hold input until the pipe runs empty, then burst again
	task automatic test_drain_pause();
		test_random(0, 25, 50);
		drain();
		test_random(0, 0, 50);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		gap_pct = 0;
		stall_pct = 0;
		n_points = 0;
		n_results = 0;
		n_invalid = 0;
		n_errors = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(0, 0, 480);
		test_random(49, 0, 350);
		test_random(0, 49, 350);
		test_random(25, 25, 350);
		test_drain_pause();
		gap_pct = 0;
		stall_pct = 0;
		drain();
		repeat (150) @(negedge clk);
		$display("converted %0d points (%0d out of range), checked %0d results",
			n_points, n_invalid, n_results);
		$display("phases: full rate, sender gaps, receiver stalls, both, drain pause");
		if (n_errors == 0 && expected_points.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* geodetic_to_ecef_converter.f */
+incdir+hdl
hdl/g2e_pkg.sv
hdl/g2e_mul.sv
hdl/g2e_dly.sv
hdl/g2e_smul.sv
hdl/g2e_sincos.sv
hdl/g2e_rsqrt.sv
hdl/geodetic_to_ecef_converter.sv
tb/sv/tb_geodetic_to_ecef_converter.sv
